### rtl/core/olid_pkg.sv
// Shared types and constants for the ordered list insert/delete unit.
package olid_pkg;

	// Default list geometry.
	localparam int DEPTH_DEF = 64;
	localparam int WIDTH_DEF = 32;

	// Width of the position, found position and count fields.
	localparam int POS_W = 7;

	// Widest cell index the chain supports (up to 1024 cells).
	localparam int IDX_W_MAX = 10;

	// Request operations.
	typedef enum logic [1:0] {
		MODE_READ   = 2'd0,
		MODE_FIND   = 2'd1,
		MODE_INSERT = 2'd2,
		MODE_DELETE = 2'd3
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// What every cell does on the next clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_ROTATE = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_DELETE = 2'd3
	} cell_op_t;

	// Broadcast command to the row of cells.
	typedef struct packed {
		cell_op_t               op;
		logic [IDX_W_MAX-1:0]   idx;
	} cell_ctrl_t;

endpackage

### rtl/core/olid_cell.sv
// One list cell: holds a single entry and shifts it to or from its neighbours.
module olid_cell #(
	parameter int INDEX = 0,
	parameter int WIDTH = olid_pkg::WIDTH_DEF
) (
	input  logic                 clk,
	input  olid_pkg::cell_ctrl_t ctrl,
	input  logic [WIDTH-1:0]     new_value,
	input  logic [WIDTH-1:0]     prev_value,
	input  logic [WIDTH-1:0]     next_value,
	output logic [WIDTH-1:0]     value
);
	import olid_pkg::*;

	localparam logic [IDX_W_MAX-1:0] MY_IDX = IDX_W_MAX'(INDEX);

	logic [WIDTH-1:0] entry_q;
	logic             at_idx;
	logic             past_idx;

	// Position of this cell relative to the broadcast index.
	assign at_idx   = (ctrl.idx == MY_IDX);
	assign past_idx = (ctrl.idx < MY_IDX);

	// Entry update: rotate towards the head, open a gap, or close one.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_ROTATE: entry_q <= next_value;
			CELL_INSERT: begin
				if (at_idx) begin
					entry_q <= new_value;
				end else if (past_idx) begin
					entry_q <= prev_value;
				end
			end
			CELL_DELETE: begin
				if (at_idx || past_idx) begin
					entry_q <= next_value;
				end
			end
			default: entry_q <= entry_q;
		endcase
	end

	assign value = entry_q;

endmodule

### rtl/core/olid_chain.sv
// Ring of list cells; the head cell is visible to the controller.
module olid_chain #(
	parameter int DEPTH = olid_pkg::DEPTH_DEF,
	parameter int WIDTH = olid_pkg::WIDTH_DEF
) (
	input  logic                 clk,
	input  olid_pkg::cell_ctrl_t ctrl,
	input  logic [WIDTH-1:0]     new_value,
	output logic [WIDTH-1:0]     head
);
	import olid_pkg::*;

	logic [WIDTH-1:0] ent [DEPTH];

	// Cells see neighbours, new_value below cell 0; the last wraps to the head.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int NXT = (i + 1) % DEPTH;
		logic [WIDTH-1:0] prev_v;

		if (i == 0) begin : g_first
			assign prev_v = new_value;
		end else begin : g_rest
			assign prev_v = ent[i-1];
		end

		olid_cell #(
			.INDEX (i),
			.WIDTH (WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_value  (new_value),
			.prev_value (prev_v),
			.next_value (ent[NXT]),
			.value      (ent[i])
		);
	end

	assign head = ent[0];

endmodule

### rtl/core/ordered_list_insert_delete_unit.sv
// Top level of the ordered list unit: request control, scan and result register.
// Read, find and good delete scan the ring: the cells rotate once all the way round past the head cell
// before the result is committed; insert and failed requests go straight to the commit state.
// A new request is taken only when the controller is idle, once the last result has been committed.
// Reset clears the count, the controller and the result valid; entries are not cleared.
module ordered_list_insert_delete_unit #(
	parameter int DEPTH = olid_pkg::DEPTH_DEF,
	parameter int WIDTH = olid_pkg::WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 mode,
	input  logic [olid_pkg::POS_W-1:0] position,
	input  logic [WIDTH-1:0]           value_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [WIDTH-1:0]           value_out,
	output logic [olid_pkg::POS_W-1:0] found_position,
	output logic [1:0]                 status,
	output logic [olid_pkg::POS_W-1:0] count
);
	import olid_pkg::*;

	localparam int CW    = $clog2(DEPTH + 1);
	localparam int IW    = $clog2(DEPTH);
	localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic               out_valid_q;
	logic [WIDTH-1:0]   out_value_q;
	logic [POS_W-1:0]   out_found_q;
	status_t            out_status_q;
	logic [POS_W-1:0]   out_count_q;

	logic [1:0]         mode_q;
	logic [POS_W-1:0]   pos_q;
	logic [WIDTH-1:0]   val_q;
	status_t            st_q;
	logic [WIDTH-1:0]   cap_q;
	logic [POS_W-1:0]   found_q;
	logic [IW-1:0]      k_q;

	logic               accept;
	logic               out_free;
	logic               commit;
	status_t            acc_status;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   cnt_x;
	logic [CMP_W-1:0]   k_x;
	logic [CW-1:0]      count_next;
	logic [WIDTH-1:0]   head;
	cell_ctrl_t         ctrl;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign commit   = (state_q == S_DONE) && out_free;

	// Request checks against the count at accept time.
	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(count_q);

	always_comb begin
		acc_status = ST_OK;
		case (mode)
			MODE_READ: begin
				if (pos_x == '0 || pos_x > cnt_x) begin
					acc_status = ST_RANGE;
				end
			end
			MODE_FIND: acc_status = ST_OK;
			MODE_INSERT: begin
				if (cnt_x >= CMP_W'(DEPTH)) begin
					acc_status = ST_FULL;
				end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
					acc_status = ST_RANGE;
				end
			end
			MODE_DELETE: begin
				if (cnt_x == '0) begin
					acc_status = ST_EMPTY;
				end else if (pos_x == '0 || pos_x > cnt_x) begin
					acc_status = ST_RANGE;
				end
			end
			default: acc_status = ST_OK;
		endcase
	end

	// Count after the current request is committed.
	always_comb begin
		count_next = count_q;
		if (st_q == ST_OK && mode_q == MODE_INSERT) begin
			count_next = count_q + CW'(1);
		end else if (st_q == ST_OK && mode_q == MODE_DELETE) begin
			count_next = count_q - CW'(1);
		end
	end

	// Command to the cells: rotate while scanning, shift on commit.
	always_comb begin
		ctrl.op  = CELL_HOLD;
		ctrl.idx = IDX_W_MAX'(pos_q) - IDX_W_MAX'(1);
		if (state_q == S_SCAN) begin
			ctrl.op = CELL_ROTATE;
		end else if (commit && st_q == ST_OK && mode_q == MODE_INSERT) begin
			ctrl.op = CELL_INSERT;
		end else if (commit && st_q == ST_OK && mode_q == MODE_DELETE) begin
			ctrl.op = CELL_DELETE;
		end
	end

	olid_chain #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.new_value (val_q),
		.head      (head)
	);

	// The head cell holds entry k during scan step k.
	assign k_x = CMP_W'(k_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			pos_q   <= position;
			val_q   <= value_in;
			st_q    <= acc_status;
			cap_q   <= '0;
			found_q <= '0;
			k_q     <= '0;
		end else if (state_q == S_SCAN) begin
			k_q <= k_q + IW'(1);
			if ((mode_q == MODE_READ || mode_q == MODE_DELETE)
					&& (k_x + CMP_W'(1) == CMP_W'(pos_q))) begin
				cap_q <= head;
			end
			if (mode_q == MODE_FIND && found_q == '0 && k_x < cnt_x && head == val_q) begin
				found_q <= POS_W'(k_x + CMP_W'(1));
			end
		end
	end

	// Controller state, count and result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_found_q  <= '0;
			out_status_q <= ST_OK;
			out_count_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall && !commit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (acc_status == ST_OK && mode != MODE_INSERT) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (k_q == IW'(DEPTH - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= cap_q;
						out_found_q  <= found_q;
						out_status_q <= st_q;
						out_count_q  <= POS_W'(count_next);
						count_q      <= count_next;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign value_out      = out_value_q;
	assign found_position = out_found_q;
	assign status         = out_status_q;
	assign count          = out_count_q;

`ifndef NO_ASSERTIONS
	// The live count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(DEPTH))
		else $error("list count exceeds depth");

	// A new result word only appears after the commit state.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result word raised outside commit");

	// A failed request leaves the count unchanged.
	a_error_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && st_q != ST_OK) |=> (count_q == $past(count_q)))
		else $error("count changed on a failed request");

	// A found position always lies within the list.
	a_found_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_found_q <= out_count_q))
		else $error("found position beyond list count");
`endif

endmodule
